// ===== design/scr_pkg.sv =====
package scr_pkg;

  // field widths
  localparam int unsigned DataW = 8;
  localparam int unsigned SlotW = 3;
  localparam int unsigned LenW  = 12;
  localparam int unsigned PosW  = 12;
  localparam int unsigned WordW = 32;
  localparam int unsigned AddrW = 3;

  // sector geometry
  localparam int unsigned SlotCount   = 4;
  localparam int unsigned SectorBytes = 4096;

  localparam logic [WordW-1:0] CrcPoly     = 32'hEDB88320;
  localparam logic [WordW-1:0] CrcInit     = 32'hFFFFFFFF;
  localparam logic [WordW-1:0] MagicReset  = 32'h56534354;
  localparam logic [LenW-1:0]  MaxLenReset = 12'd2032;
  localparam logic [PosW-1:0]  HeaderBytes = 12'd12;

  // position of the last byte of each header word
  localparam logic [PosW-1:0] MagicLastPos = 12'd3;
  localparam logic [PosW-1:0] SeqLastPos   = 12'd7;
  localparam logic [PosW-1:0] LenLastPos   = 12'd11;

  typedef enum logic {
    REG_MAGIC   = 1'b0,
    REG_MAX_LEN = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SLOT  = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_CRC_BAD   = 3'd4,
    ST_TRUNC     = 3'd5
  } status_e;

  typedef struct packed {
    logic [WordW-1:0] magic;
    logic [LenW-1:0]  max_len;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    logic [LenW-1:0]  record_len;
    logic [WordW-1:0] sequence_res;
    logic [SlotW-1:0] slot_echo;
  } result_t;

  // reflected crc-32, one byte, eight bit steps
  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc_in,
                                                input logic [DataW-1:0] data);
    logic [WordW-1:0] c;
    c = crc_in ^ {{(WordW-DataW){1'b0}}, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : '0);
    end
    return c;
  endfunction

endpackage

// ===== design/scr_if.sv =====
interface scr_in_if;
  logic                      valid;
  logic                      ready;
  logic [scr_pkg::DataW-1:0] data_byte;
  logic [scr_pkg::SlotW-1:0] slot_index;
  logic                      last_byte;

  modport source (output valid, data_byte, slot_index, last_byte, input ready);
  modport sink (input valid, data_byte, slot_index, last_byte, output ready);
endinterface

interface scr_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [scr_pkg::LenW-1:0]  record_len;
  logic [scr_pkg::WordW-1:0] sequence_res;
  logic [scr_pkg::SlotW-1:0] slot_echo;

  modport source (output valid, status, record_len, sequence_res, slot_echo, input ready);
  modport sink (input valid, status, record_len, sequence_res, slot_echo, output ready);
endinterface

// ===== design/scr_cfg.sv =====
module scr_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [scr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output scr_pkg::cfg_t             cfg_o
);
  import scr_pkg::*;

  logic [WordW-1:0] magic_q;
  logic [LenW-1:0]  max_len_q;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= MagicReset;
      max_len_q <= MaxLenReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAGIC:   magic_q   <= pwdata;
        REG_MAX_LEN: max_len_q <= pwdata[LenW-1:0];
        default:     ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_MAGIC:   prdata = magic_q;
      REG_MAX_LEN: prdata = {{(32-LenW){1'b0}}, max_len_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = '{magic: magic_q, max_len: max_len_q};

endmodule

// ===== design/scr_frame.sv =====
module scr_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  scr_in_if.sink            in_i,
  input  scr_pkg::cfg_t     cfg_i,
  output logic              res_vld_o,
  input  logic              res_rdy_i,
  output scr_pkg::result_t  res_o
);
  import scr_pkg::*;

  // input register
  logic             hold_vld_q;
  logic [DataW-1:0] byte_q;
  logic [SlotW-1:0] slot_q;
  logic             last_q;
  logic             adv;

  // sector state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [WordW-1:0] crc_q, crc_d;
  logic [WordW-1:0] ws_q, ws_d;
  logic [WordW-1:0] seq_q, seq_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [PosW-1:0]  chk_q, chk_d;
  logic             given_q, given_d;
  logic [SlotW-1:0] held_q, held_d;

  // per-item terms
  logic [SlotW-1:0] slot_cur;
  logic [WordW-1:0] crc_base, crc_upd, ws_new;
  logic             first, bad_slot, in_crc, too_long, at_check, found;
  logic [PosW:0]    off;
  logic [PosW+1:0]  off_end;
  logic [PosW:0]    chk_last;
  status_e          st;

  assign adv         = hold_vld_q & res_rdy_i;
  assign in_i.ready  = ~hold_vld_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      hold_vld_q <= 1'b1;
    end else if (adv) begin
      hold_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
      slot_q <= in_i.slot_index;
      last_q <= in_i.last_byte;
    end
  end

  // header decode and crc terms
  assign first    = (pos_q == '0);
  assign slot_cur = first ? slot_q : held_q;
  assign crc_base = first ? CrcInit : crc_q;
  assign bad_slot = first && ({1'b0, slot_q} >= (SlotW+1)'(SlotCount));
  assign ws_new   = {byte_q, ws_q[WordW-1:DataW]};
  assign in_crc   = (pos_q < HeaderBytes) || (pos_q < chk_q);
  assign crc_upd  = in_crc ? crc_byte(crc_base, byte_q) : crc_base;
  assign off      = ({1'b0, ws_new[LenW-1:0]} + (PosW+1)'(15)) & ~(PosW+1)'(3);
  assign off_end  = {1'b0, off} + (PosW+2)'(4);
  assign too_long = (ws_new[WordW-1:LenW] != '0) || (ws_new[LenW-1:0] > cfg_i.max_len)
                    || (off_end > (PosW+2)'(SectorBytes));
  assign chk_last = {1'b0, chk_q} + (PosW+1)'(3);
  assign at_check = (pos_q >= HeaderBytes) && ({1'b0, pos_q} == chk_last);

  // next state and verdict
  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    ws_d    = ws_q;
    seq_d   = seq_q;
    len_d   = len_q;
    chk_d   = chk_q;
    given_d = given_q;
    held_d  = held_q;
    found   = 1'b0;
    st      = ST_OK;
    res_vld_o = 1'b0;
    res_o     = '{status: ST_OK, record_len: '0, sequence_res: '0, slot_echo: held_q};
    if (adv) begin
      if (!given_q) begin
        held_d = slot_cur;
        crc_d  = crc_base;
        if (bad_slot) begin
          found = 1'b1;
          st    = ST_BAD_SLOT;
        end else begin
          crc_d = crc_upd;
          ws_d  = ws_new;
          if (pos_q == MagicLastPos && ws_new != cfg_i.magic) begin
            found = 1'b1;
            st    = ST_BAD_MAGIC;
          end else if (pos_q == SeqLastPos) begin
            seq_d = ws_new;
          end else if (pos_q == LenLastPos) begin
            if (too_long) begin
              found = 1'b1;
              st    = ST_TOO_LONG;
            end else begin
              len_d = ws_new[LenW-1:0];
              chk_d = off[PosW-1:0];
            end
          end else if (at_check) begin
            found = 1'b1;
            st    = (~crc_upd == ws_new) ? ST_OK : ST_CRC_BAD;
          end
          pos_d = pos_q + 1'b1;
        end
        given_d = found;
      end
      res_o.slot_echo = held_d;
      if (found) begin
        res_vld_o     = 1'b1;
        res_o.status  = st;
        if (st == ST_OK) begin
          res_o.record_len   = len_q;
          res_o.sequence_res = seq_q;
        end
      end else if (last_q && !given_q) begin
        res_vld_o    = 1'b1;
        res_o.status = ST_TRUNC;
      end
      // sector end
      if (last_q) begin
        pos_d   = '0;
        crc_d   = CrcInit;
        ws_d    = '0;
        seq_d   = '0;
        len_d   = '0;
        chk_d   = '0;
        given_d = 1'b0;
        held_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= CrcInit;
      ws_q    <= '0;
      seq_q   <= '0;
      len_q   <= '0;
      chk_q   <= '0;
      given_q <= 1'b0;
      held_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      ws_q    <= ws_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
      chk_q   <= chk_d;
      given_q <= given_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== design/scr_out_reg.sv =====
module scr_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_vld_i,
  output logic             res_rdy_o,
  input  scr_pkg::result_t res_i,
  scr_out_if.source        out_o
);
  import scr_pkg::*;

  logic    vld_q;
  result_t res_q;

  assign res_rdy_o = ~vld_q | out_o.ready;

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (res_vld_i && res_rdy_o) begin
      vld_q <= 1'b1;
    end else if (out_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld_i && res_rdy_o) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = vld_q;
  assign out_o.status       = res_q.status;
  assign out_o.record_len   = res_q.record_len;
  assign out_o.sequence_res = res_q.sequence_res;
  assign out_o.slot_echo    = res_q.slot_echo;

endmodule

// ===== design/save_record_checker.sv =====
// flow: an accepted item waits in the input register until the result register can
//   take it; it is then decided and its verdict is registered and offered from there
// throughput: one sector byte per cycle while the output is not stalled, set by
//   the byte-wide crc-32 step between the input and result registers
// reset: asynchronous, active low; clears sector state, empties both registers
//   and loads the configuration registers with their defaults
module save_record_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  scr_in_if.sink                    in_i,
  scr_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [scr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import scr_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_vld;
  logic    res_rdy;

  // configuration registers
  scr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sector parser and crc
  scr_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg),
    .res_vld_o (res_vld),
    .res_rdy_i (res_rdy),
    .res_o     (res)
  );

  // result register
  scr_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_vld_i (res_vld),
    .res_rdy_o (res_rdy),
    .res_i     (res),
    .out_o     (out_o)
  );

  // a verdict is only produced when the result register can take it
  a_res_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> res_rdy)
    else $error("verdict produced while result register is blocked");

  // input stalls only under output back-pressure
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without output back-pressure");

  // failed verdicts carry no length or sequence
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |->
      (out_o.record_len == '0 && out_o.sequence_res == '0))
    else $error("failed verdict with nonzero length or sequence");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import scr_pkg::*;

  // one byte of the sector stream as the sender offers it
  typedef struct packed {
    logic [DataW-1:0] data;
    logic [SlotW-1:0] slot;
    logic             last;
  } sector_byte_t;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int PhaseBytes = 230;

  logic clk_i;
  logic rst_ni;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  scr_in_if  in_if ();
  scr_out_if out_if ();

  save_record_checker DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // stimulus and expectation stores
  sector_byte_t bytes_to_send[$];
  result_t      verdicts_due[$];

  // idling knobs: idle and stall percent of cycles, and long sink hold-offs
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_requests = 0;
  int holds_begun = 0;
  int hold_left = 0;

  // bookkeeping
  int mismatches = 0;
  int bytes_built = 0;
  int sectors_built = 0;
  int bytes_taken = 0;
  int verdicts_taken = 0;
  int status_hits[8];
  int quiet_cycles = 0;

  // checker model: configuration copy
  logic [WordW-1:0] cfg_magic = MagicReset;
  logic [LenW-1:0]  cfg_max_len = MaxLenReset;

  // checker model: per-sector state
  logic [PosW-1:0]  sec_pos = '0;
  logic [WordW-1:0] crc_acc = '1;
  logic [WordW-1:0] shift_word = '0;
  logic [WordW-1:0] seq_held = '0;
  logic [LenW-1:0]  len_held = '0;
  logic [PosW-1:0]  chk_off = '0;
  logic             decided = 1'b0;
  logic [SlotW-1:0] slot_held = '0;

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // reflected crc-32 over one byte, lsb first
  function automatic logic [WordW-1:0] crc32_step(input logic [WordW-1:0] c_in,
                                                  input logic [DataW-1:0] d);
    logic [WordW-1:0] c;
    c = c_in ^ {24'h0, d};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[WordW-1:1]} ^ ({WordW{c[0]}} & CrcPoly);
    end
    return c;
  endfunction

  function automatic result_t verdict_of(input status_e s, input logic [LenW-1:0] len,
                                         input logic [WordW-1:0] seq);
    result_t r;
    r.status       = s;
    r.record_len   = len;
    r.sequence_res = seq;
    r.slot_echo    = slot_held;
    return r;
  endfunction

  task automatic clear_sector_state();
    sec_pos    = '0;
    crc_acc    = '1;
    shift_word = '0;
    seq_held   = '0;
    len_held   = '0;
    chk_off    = '0;
    decided    = 1'b0;
    slot_held  = '0;
  endtask

  // advance the checker model by one accepted byte, queue any verdict
  task automatic judge_byte(input sector_byte_t it);
    result_t         r;
    bit              have;
    longint unsigned len_w;
    longint unsigned off_w;
    have = 1'b0;
    if (!decided) begin
      if (sec_pos == '0) begin
        slot_held = it.slot;
        crc_acc   = CrcInit;
      end
      if (sec_pos == '0 && slot_held >= SlotCount) begin
        r    = verdict_of(ST_BAD_SLOT, '0, '0);
        have = 1'b1;
      end else begin
        if (sec_pos < HeaderBytes || sec_pos < chk_off) crc_acc = crc32_step(crc_acc, it.data);
        shift_word = {it.data, shift_word[WordW-1:8]};
        if (sec_pos == MagicLastPos && shift_word != cfg_magic) begin
          r    = verdict_of(ST_BAD_MAGIC, '0, '0);
          have = 1'b1;
        end else if (sec_pos == SeqLastPos) begin
          seq_held = shift_word;
        end else if (sec_pos == LenLastPos) begin
          len_w = shift_word;
          off_w = (len_w + HeaderBytes + 3) & ~64'd3;
          if (len_w > cfg_max_len || off_w + 4 > SectorBytes) begin
            r    = verdict_of(ST_TOO_LONG, '0, '0);
            have = 1'b1;
          end else begin
            len_held = len_w[LenW-1:0];
            chk_off  = off_w[PosW-1:0];
          end
        end else if (sec_pos >= HeaderBytes && 32'(sec_pos) == 32'(chk_off) + 3) begin
          if (~crc_acc == shift_word) r = verdict_of(ST_OK, len_held, seq_held);
          else r = verdict_of(ST_CRC_BAD, '0, '0);
          have = 1'b1;
        end
        sec_pos = sec_pos + 1'b1;
      end
      if (have) decided = 1'b1;
    end
    // last-byte mark closes the sector
    if (it.last) begin
      if (!decided) begin
        r    = verdict_of(ST_TRUNC, '0, '0);
        have = 1'b1;
      end
      clear_sector_state();
    end
    if (have) verdicts_due.push_back(r);
  endtask

  // build one sector image and queue its bytes; mark_at < 0 marks the end
  task automatic push_sector(input logic [SlotW-1:0] slot, input logic [WordW-1:0] magic,
                             input logic [WordW-1:0] len_word, input int body_len,
                             input logic [WordW-1:0] spoil, input int extra,
                             input int mark_at);
    logic [DataW-1:0] img[$];
    logic [WordW-1:0] seq;
    logic [WordW-1:0] crc;
    logic [WordW-1:0] chk;
    sector_byte_t     b;
    int               n;
    seq = $urandom;
    for (int k = 0; k < 4; k++) img.push_back(magic[8*k +: 8]);
    for (int k = 0; k < 4; k++) img.push_back(seq[8*k +: 8]);
    for (int k = 0; k < 4; k++) img.push_back(len_word[8*k +: 8]);
    for (int k = 0; k < body_len; k++) img.push_back(8'($urandom));
    while (img.size() % 4 != 0) img.push_back(8'($urandom));
    crc = CrcInit;
    foreach (img[k]) crc = crc32_step(crc, img[k]);
    chk = ~crc ^ spoil;
    for (int k = 0; k < 4; k++) img.push_back(chk[8*k +: 8]);
    for (int k = 0; k < extra; k++) img.push_back(8'($urandom));
    n = (mark_at >= 0 && mark_at < img.size()) ? mark_at + 1 : img.size();
    for (int k = 0; k < n; k++) begin
      b.data = img[k];
      b.slot = (k == 0) ? slot : SlotW'($urandom_range(7));
      b.last = (k == n - 1);
      bytes_to_send.push_back(b);
    end
    bytes_built += n;
    sectors_built++;
  endtask

  // unstructured bytes closed by a mark
  task automatic push_noise(input int n);
    sector_byte_t b;
    for (int k = 0; k < n; k++) begin
      b.data = 8'($urandom);
      b.slot = SlotW'($urandom_range(7));
      b.last = (k == n - 1);
      bytes_to_send.push_back(b);
    end
    bytes_built += n;
    sectors_built++;
  endtask

  // mostly well-formed sectors, the rest broken in one way or another
  task automatic random_sector();
    int               pick;
    int               len;
    int               off;
    int               mark_at;
    int               extra;
    int               mark_pick;
    logic [SlotW-1:0] slot;
    logic [WordW-1:0] magic;
    logic [WordW-1:0] spoil;
    logic [WordW-1:0] len_word;
    pick  = $urandom_range(99);
    slot  = SlotW'($urandom_range(SlotCount - 1));
    magic = cfg_magic;
    spoil = '0;
    extra = $urandom_range(3);
    if (cfg_max_len <= 48 && $urandom_range(3) == 0) len = cfg_max_len + $urandom_range(1);
    else len = $urandom_range(24);
    len_word  = len;
    off       = (len + 15) & ~3;
    mark_pick = $urandom_range(9);
    if (mark_pick == 0) mark_at = $urandom_range(off + 2);
    else if (mark_pick == 1) mark_at = off + 3;
    else mark_at = -1;
    if (pick < 65) begin
      if ($urandom_range(7) == 0) spoil = 32'd1 << $urandom_range(31);
    end else if (pick < 78) begin
      magic = magic ^ (32'd1 << $urandom_range(31));
    end else if (pick < 88) begin
      slot = SlotW'($urandom_range(7, SlotCount));
    end else if (pick < 94) begin
      len_word = $urandom | 32'h0000_1000;
    end else begin
      push_noise($urandom_range(1, 20));
      return;
    end
    push_sector(slot, magic, len_word, len, spoil, extra, mark_at);
  endtask

  // configuration bus: setup then access, pready tied high by the block
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_check(input reg_idx_e idx, input logic [31:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $error("register %s mismatch: expected %0h actual %0h", idx.name(), want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [WordW-1:0] magic, input logic [LenW-1:0] max_len);
    reg_write(REG_MAGIC, magic);
    reg_write(REG_MAX_LEN, {20'h0, max_len});
    cfg_magic   = magic;
    cfg_max_len = max_len;
    reg_check(REG_MAGIC, magic);
    reg_check(REG_MAX_LEN, {20'h0, max_len});
  endtask

  // block drained: nothing queued, nothing offered, nothing owed
  task automatic wait_drained(input int settle);
    while (bytes_to_send.size() != 0 || verdicts_due.size() != 0 || in_if.valid)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // byte driver: predicts on acceptance, then offers the next queued byte
  always @(posedge clk_i) begin : byte_driver
    sector_byte_t got;
    sector_byte_t nxt;
    bit           send;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        got.data = in_if.data_byte;
        got.slot = in_if.slot_index;
        got.last = in_if.last_byte;
        judge_byte(got);
        bytes_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        send = bytes_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct;
        if (send) begin
          nxt = bytes_to_send.pop_front();
          in_if.data_byte  <= nxt.data;
          in_if.slot_index <= nxt.slot;
          in_if.last_byte  <= nxt.last;
        end
        in_if.valid <= send;
      end
    end
  end

  // verdict monitor: compares each accepted verdict, drives ready
  always @(posedge clk_i) begin : verdict_monitor
    result_t want;
    bit      rdy;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        verdicts_taken++;
        status_hits[out_if.status]++;
        if (verdicts_due.size() == 0) begin
          $error("unexpected verdict: status %0d slot %0d", out_if.status, out_if.slot_echo);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_if.status !== want.status) begin
            $error("status mismatch: expected %0d actual %0d", want.status, out_if.status);
            mismatches++;
          end
          if (out_if.record_len !== want.record_len) begin
            $error("record_len mismatch: expected %0d actual %0d",
                   want.record_len, out_if.record_len);
            mismatches++;
          end
          if (out_if.sequence_res !== want.sequence_res) begin
            $error("sequence_res mismatch: expected %0h actual %0h",
                   want.sequence_res, out_if.sequence_res);
            mismatches++;
          end
          if (out_if.slot_echo !== want.slot_echo) begin
            $error("slot_echo mismatch: expected %0d actual %0d",
                   want.slot_echo, out_if.slot_echo);
            mismatches++;
          end
        end
      end
      // long hold-off so the block backs up into its input
      if (holds_begun < hold_requests) begin
        hold_left = HoldCycles;
        holds_begun++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = $urandom_range(99) >= snk_stall_pct;
      end
      out_if.ready <= rdy;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // main sequence
  initial begin
    int phase_start;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.slot_index = '0;
    in_if.last_byte  = 1'b0;
    out_if.ready     = 1'b0;
    foreach (status_hits[k]) status_hits[k] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset configuration
    push_sector(3'd7, MagicReset, 32'd0, 0, '0, 0, 0);           // bad slot on a marked byte
    push_sector(3'd0, MagicReset, 32'd0, 0, '0, 0, 0);           // mark on the first byte
    push_sector(3'd1, ~MagicReset, 32'd0, 0, '0, 0, 3);          // bad magic on the marked byte
    push_sector(3'd2, MagicReset, 32'd0, 0, '0, 0, -1);          // empty record
    push_sector(3'd3, MagicReset, 32'hFFFF_FFFF, 0, '0, 0, 11);  // huge length word
    wait_drained(4);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 0;  snk_stall_pct = 0;
          set_config(MagicReset, MaxLenReset);
        end
        1: begin
          src_idle_pct = 69; snk_stall_pct = 0;
          set_config(32'h0000_0000, 12'd0);
        end
        2: begin
          src_idle_pct = 0;  snk_stall_pct = 69;
          set_config(32'hFFFF_FFFF, 12'd4084);
          // largest length that fits, cut after the header, then lengths past the sector end
          push_sector(3'd3, cfg_magic, 32'd4080, 0, '0, 0, 11);
          push_sector(3'd1, cfg_magic, 32'd4081, 0, '0, 0, 11);
          push_sector(3'd2, cfg_magic, 32'd4085, 0, '0, 0, 11);
        end
        3: begin
          src_idle_pct = 29; snk_stall_pct = 29;
          set_config($urandom, LenW'($urandom_range(1, 40)));
        end
        default: begin
          src_idle_pct = 0;  snk_stall_pct = 0;
          set_config(MagicReset, MaxLenReset);
          hold_requests++;
        end
      endcase
      phase_start = bytes_built;
      while (bytes_built - phase_start < PhaseBytes) random_sector();
      wait_drained(4);
    end

    wait_drained(8);
    $display("run covered %0d sector bytes in %0d sectors, %0d verdicts checked",
             bytes_taken, sectors_built, verdicts_taken);
    $display("verdicts by status: ok %0d, slot %0d, magic %0d, long %0d, crc %0d, trunc %0d",
             status_hits[0], status_hits[1], status_hits[2],
             status_hits[3], status_hits[4], status_hits[5]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/scr_pkg.sv
design/scr_if.sv
design/scr_cfg.sv
design/scr_frame.sv
design/scr_out_reg.sv
design/save_record_checker.sv
dv/tb_top.sv
